// ----- rtl/mlfc_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfc_pkg
// Shared types, codes and reset values for the motion light fade controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfc_pkg;

    // Upper clamp on the effective ring count
    localparam int MAX_RINGS = 16;

    // Event kinds
    localparam logic [2:0] EV_TICK      = 3'd0;
    localparam logic [2:0] EV_CORRIDOR  = 3'd1;
    localparam logic [2:0] EV_RING      = 3'd2;
    localparam logic [2:0] EV_ALARM_SET = 3'd3;
    localparam logic [2:0] EV_ALARM_CLR = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_FRAME_INTERVAL   = 3'd0;
    localparam logic [2:0] CFG_HOLD_TIME        = 3'd1;
    localparam logic [2:0] CFG_FADE_STEP        = 3'd2;
    localparam logic [2:0] CFG_FULL_BRIGHTNESS  = 3'd3;
    localparam logic [2:0] CFG_REVEAL_STEP_TIME = 3'd4;
    localparam logic [2:0] CFG_FLASH_PERIOD     = 3'd5;
    localparam logic [2:0] CFG_RING_COUNT       = 3'd6;
    localparam logic [2:0] CFG_RINGS_ENABLED    = 3'd7;

    // Configuration reset values
    localparam logic [15:0] RST_FRAME_INTERVAL   = 16'd20;
    localparam logic [31:0] RST_HOLD_TIME        = 32'd5000;
    localparam logic [7:0]  RST_FADE_STEP        = 8'd5;
    localparam logic [7:0]  RST_FULL_BRIGHTNESS  = 8'd200;
    localparam logic [15:0] RST_REVEAL_STEP_TIME = 16'd100;
    localparam logic [15:0] RST_FLASH_PERIOD     = 16'd250;
    localparam logic [4:0]  RST_RING_COUNT       = 5'd4;
    localparam logic        RST_RINGS_ENABLED    = 1'b1;

    // Reported phase codes
    localparam logic [1:0] PHASE_OFF  = 2'd0;
    localparam logic [1:0] PHASE_RISE = 2'd1;
    localparam logic [1:0] PHASE_HOLD = 2'd2;
    localparam logic [1:0] PHASE_FALL = 2'd3;

    // Lighting machine state (rise is fade in for the corridor, reveal for rings)
    typedef enum logic [3:0] {
        MODE_OFF  = 4'b0001,
        MODE_RISE = 4'b0010,
        MODE_HOLD = 4'b0100,
        MODE_FALL = 4'b1000
    } mode_t;

    function automatic logic [1:0] phase_code(mode_t m);
        logic [1:0] p;
        case (m)
            MODE_OFF:  p = PHASE_OFF;
            MODE_RISE: p = PHASE_RISE;
            MODE_HOLD: p = PHASE_HOLD;
            MODE_FALL: p = PHASE_FALL;
            default:   p = PHASE_OFF;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/motion_light_fade_controller.sv -----
// ----------------------------------------------------------------------------
// motion_light_fade_controller
// Event driven corridor and ring lighting controller with alarm flash.
//
// Each accepted event beat (tick, corridor motion, ring motion, alarm set,
// alarm clear) produces exactly one result beat describing the lighting state
// after the event. Throughput is one event per clock: the full state update is
// one pass of compare/add logic from the state registers into the state and
// result registers, and s_ready stays high while the result register is empty
// or being taken in the same cycle. m_valid rises in the cycle after
// acceptance. Configuration is written through cfg_we/cfg_index/cfg_data and
// takes effect on the next event; all time compares wrap modulo 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_light_fade_controller
    import mlfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_kind,
    input  wire logic [31:0] s_now,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_frame_taken,
    output logic             m_alarm_on,
    output logic             m_flash_lit,
    output logic [7:0]       m_corridor_level,
    output logic [1:0]       m_corridor_phase,
    output logic [4:0]       m_rings_shown,
    output logic [7:0]       m_ring_level,
    output logic [1:0]       m_ring_phase
);

    // Configuration registers
    logic [15:0] frame_interval_reg;
    logic [31:0] hold_time_reg;
    logic [7:0]  fade_step_reg;
    logic [7:0]  full_brightness_reg;
    logic [15:0] reveal_step_time_reg;
    logic [15:0] flash_period_reg;
    logic [4:0]  ring_count_reg;
    logic        rings_enabled_reg;

    // Controller state
    logic        alarm_reg, alarm_next;
    logic        flash_reg, flash_next;
    logic [31:0] last_flash_reg, last_flash_next;
    logic [31:0] last_frame_reg, last_frame_next;
    mode_t       cor_mode_reg, cor_mode_next;
    logic [7:0]  cor_bright_reg, cor_bright_next;
    logic [31:0] cor_deadline_reg, cor_deadline_next;
    mode_t       ring_mode_reg, ring_mode_next;
    logic [4:0]  ring_cursor_reg, ring_cursor_next;
    logic [7:0]  ring_bright_reg, ring_bright_next;
    logic [31:0] ring_step_reg, ring_step_next;
    logic [31:0] ring_deadline_reg, ring_deadline_next;

    // Result register
    logic        out_valid_reg;
    logic        taken_reg, taken_next;
    logic [4:0]  shown_reg, shown_next;

    logic        accept;
    logic [4:0]  eff_rings;
    logic [31:0] frame_dt;
    logic [31:0] flash_dt;
    logic [31:0] reveal_dt;
    logic [31:0] hold_end;
    logic [31:0] cor_late;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Ring count clamp to 1..MAX_RINGS
    always_comb begin
        if (ring_count_reg == 5'd0) begin
            eff_rings = 5'd1;
        end else if ({3'b000, ring_count_reg} > 8'(MAX_RINGS)) begin
            eff_rings = 5'(MAX_RINGS);
        end else begin
            eff_rings = ring_count_reg;
        end
    end

    assign frame_dt  = s_now - last_frame_reg;
    assign flash_dt  = s_now - last_flash_reg;
    assign reveal_dt = s_now - ring_step_reg;
    assign hold_end  = s_now + hold_time_reg;
    assign cor_late  = s_now - cor_deadline_reg;

    // Next state for one event
    always_comb begin
        logic [8:0]  cor_sum;
        logic [31:0] ring_late;
        cor_sum            = {1'b0, cor_bright_reg} + {1'b0, fade_step_reg};
        ring_late          = s_now - ring_deadline_reg;
        alarm_next         = alarm_reg;
        flash_next         = flash_reg;
        last_flash_next    = last_flash_reg;
        last_frame_next    = last_frame_reg;
        cor_mode_next      = cor_mode_reg;
        cor_bright_next    = cor_bright_reg;
        cor_deadline_next  = cor_deadline_reg;
        ring_mode_next     = ring_mode_reg;
        ring_cursor_next   = ring_cursor_reg;
        ring_bright_next   = ring_bright_reg;
        ring_step_next     = ring_step_reg;
        ring_deadline_next = ring_deadline_reg;
        taken_next         = 1'b0;

        // disabled ring machine is held off on every event
        if (!rings_enabled_reg) begin
            ring_mode_next   = MODE_OFF;
            ring_cursor_next = 5'd0;
            ring_bright_next = 8'd0;
        end

        case (s_kind)
            EV_TICK: begin
                if (frame_dt >= {16'd0, frame_interval_reg}) begin
                    taken_next      = 1'b1;
                    last_frame_next = s_now;
                    if (alarm_reg) begin
                        // alarm: only the flash advances
                        if (flash_dt >= {16'd0, flash_period_reg}) begin
                            last_flash_next = s_now;
                            flash_next      = !flash_reg;
                        end
                    end else begin
                        // ring machine
                        case (ring_mode_next)
                            MODE_RISE: begin
                                if (reveal_dt >= {16'd0, reveal_step_time_reg}) begin
                                    ring_step_next   = s_now;
                                    ring_cursor_next = ring_cursor_reg + 5'd1;
                                    if (ring_cursor_next >= eff_rings) begin
                                        ring_mode_next     = MODE_HOLD;
                                        ring_deadline_next = hold_end;
                                    end
                                end
                            end
                            MODE_HOLD: begin
                                if (!ring_late[31]) begin
                                    ring_mode_next = MODE_FALL;
                                end
                            end
                            MODE_FALL: begin
                                if (ring_bright_reg <= fade_step_reg) begin
                                    ring_bright_next = 8'd0;
                                    ring_mode_next   = MODE_OFF;
                                end else begin
                                    ring_bright_next = ring_bright_reg - fade_step_reg;
                                end
                            end
                            default: ;
                        endcase
                        // corridor machine
                        case (cor_mode_reg)
                            MODE_RISE: begin
                                if (cor_sum >= {1'b0, full_brightness_reg}) begin
                                    cor_bright_next = full_brightness_reg;
                                    cor_mode_next   = MODE_HOLD;
                                end else begin
                                    cor_bright_next = cor_sum[7:0];
                                end
                            end
                            MODE_HOLD: begin
                                if (!cor_late[31]) begin
                                    cor_mode_next = MODE_FALL;
                                end
                            end
                            MODE_FALL: begin
                                if (cor_bright_reg <= fade_step_reg) begin
                                    cor_bright_next = 8'd0;
                                    cor_mode_next   = MODE_OFF;
                                end else begin
                                    cor_bright_next = cor_bright_reg - fade_step_reg;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            EV_CORRIDOR: begin
                if (!alarm_reg) begin
                    cor_deadline_next = hold_end;
                    if (cor_mode_reg == MODE_OFF || cor_mode_reg == MODE_FALL) begin
                        cor_mode_next = MODE_RISE;
                    end
                end
            end
            EV_RING: begin
                if (!alarm_reg && rings_enabled_reg) begin
                    ring_deadline_next = hold_end;
                    if (ring_mode_reg == MODE_OFF) begin
                        ring_mode_next   = MODE_RISE;
                        ring_cursor_next = 5'd0;
                        ring_bright_next = full_brightness_reg;
                        ring_step_next   = s_now;
                    end else if (ring_mode_reg == MODE_FALL) begin
                        ring_mode_next   = MODE_HOLD;
                        ring_bright_next = full_brightness_reg;
                    end
                end
            end
            EV_ALARM_SET: begin
                alarm_next      = 1'b1;
                flash_next      = 1'b1;
                last_flash_next = 32'd0;
            end
            EV_ALARM_CLR: begin
                alarm_next       = 1'b0;
                cor_mode_next    = MODE_OFF;
                cor_bright_next  = 8'd0;
                ring_mode_next   = MODE_OFF;
                ring_cursor_next = 5'd0;
                ring_bright_next = 8'd0;
            end
            default: ;  // unknown kind: report state only
        endcase

        // lit ring count
        if (ring_mode_next == MODE_RISE) begin
            shown_next = ring_cursor_next;
        end else if (ring_mode_next != MODE_OFF) begin
            shown_next = eff_rings;
        end else begin
            shown_next = 5'd0;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_interval_reg   <= RST_FRAME_INTERVAL;
            hold_time_reg        <= RST_HOLD_TIME;
            fade_step_reg        <= RST_FADE_STEP;
            full_brightness_reg  <= RST_FULL_BRIGHTNESS;
            reveal_step_time_reg <= RST_REVEAL_STEP_TIME;
            flash_period_reg     <= RST_FLASH_PERIOD;
            ring_count_reg       <= RST_RING_COUNT;
            rings_enabled_reg    <= RST_RINGS_ENABLED;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FRAME_INTERVAL:   frame_interval_reg   <= cfg_data[15:0];
                CFG_HOLD_TIME:        hold_time_reg        <= cfg_data;
                CFG_FADE_STEP:        fade_step_reg        <= cfg_data[7:0];
                CFG_FULL_BRIGHTNESS:  full_brightness_reg  <= cfg_data[7:0];
                CFG_REVEAL_STEP_TIME: reveal_step_time_reg <= cfg_data[15:0];
                CFG_FLASH_PERIOD:     flash_period_reg     <= cfg_data[15:0];
                CFG_RING_COUNT:       ring_count_reg       <= cfg_data[4:0];
                CFG_RINGS_ENABLED:    rings_enabled_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // State update on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_reg         <= 1'b0;
            flash_reg         <= 1'b0;
            last_flash_reg    <= 32'd0;
            last_frame_reg    <= 32'd0;
            cor_mode_reg      <= MODE_OFF;
            cor_bright_reg    <= 8'd0;
            cor_deadline_reg  <= 32'd0;
            ring_mode_reg     <= MODE_OFF;
            ring_cursor_reg   <= 5'd0;
            ring_bright_reg   <= 8'd0;
            ring_step_reg     <= 32'd0;
            ring_deadline_reg <= 32'd0;
        end else if (accept) begin
            alarm_reg         <= alarm_next;
            flash_reg         <= flash_next;
            last_flash_reg    <= last_flash_next;
            last_frame_reg    <= last_frame_next;
            cor_mode_reg      <= cor_mode_next;
            cor_bright_reg    <= cor_bright_next;
            cor_deadline_reg  <= cor_deadline_next;
            ring_mode_reg     <= ring_mode_next;
            ring_cursor_reg   <= ring_cursor_next;
            ring_bright_reg   <= ring_bright_next;
            ring_step_reg     <= ring_step_next;
            ring_deadline_reg <= ring_deadline_next;
        end
    end

    // Result beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            taken_reg <= taken_next;
            shown_reg <= shown_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_frame_taken    = taken_reg;
    assign m_alarm_on       = alarm_reg;
    assign m_flash_lit      = alarm_reg & flash_reg;
    assign m_corridor_level = (cor_mode_reg != MODE_OFF) ? cor_bright_reg : 8'd0;
    assign m_corridor_phase = phase_code(cor_mode_reg);
    assign m_rings_shown    = shown_reg;
    assign m_ring_level     = (ring_mode_reg != MODE_OFF) ? ring_bright_reg : 8'd0;
    assign m_ring_phase     = phase_code(ring_mode_reg);

`ifndef SYNTHESIS
    // every accepted event leaves a result beat behind
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted event produced no result beat");

    // alarm clear turns both machines off
    a_clear_turns_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_kind == EV_ALARM_CLR) |=>
            (cor_mode_reg == MODE_OFF && ring_mode_reg == MODE_OFF && !alarm_reg))
        else $error("alarm clear left a machine running");

    // disabled rings stay off after any event
    a_rings_disabled_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !rings_enabled_reg) |=> (ring_mode_reg == MODE_OFF))
        else $error("ring machine active while disabled");

    // flash shows only in alarm mode
    a_flash_needs_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_flash_lit) |-> m_alarm_on)
        else $error("flash lit without alarm");

    // an idle ring machine shows nothing
    a_ring_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ring_phase == PHASE_OFF) |-> (m_rings_shown == 5'd0 && m_ring_level == 8'd0))
        else $error("rings shown while ring machine off");
`endif

endmodule

`default_nettype wire

// ----- tb/lamp_state_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamp_state_checker
// Watches the event and result channels of the motion light fade controller.
// It tracks the register writes, keeps its own copy of the corridor, ring and
// alarm state, and works out the result beat for each accepted event. Each
// result beat is compared field by field against the oldest expected beat.
// ----------------------------------------------------------------------------
module lamp_state_checker
    import mlfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [31:0] s_now,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_frame_taken,
    input  logic        m_alarm_on,
    input  logic        m_flash_lit,
    input  logic [7:0]  m_corridor_level,
    input  logic [1:0]  m_corridor_phase,
    input  logic [4:0]  m_rings_shown,
    input  logic [7:0]  m_ring_level,
    input  logic [1:0]  m_ring_phase,

    output int          lamp_beats_due,
    output int          fail_count
);

    // Machine state, encoded as the phase code it reports
    typedef enum logic [1:0] {
        LAMP_OFF  = PHASE_OFF,
        LAMP_RISE = PHASE_RISE,
        LAMP_HOLD = PHASE_HOLD,
        LAMP_FALL = PHASE_FALL
    } lamp_mode_t;

    typedef struct packed {
        logic       frame_taken;
        logic       alarm_on;
        logic       flash_lit;
        logic [7:0] corridor_level;
        logic [1:0] corridor_phase;
        logic [4:0] rings_shown;
        logic [7:0] ring_level;
        logic [1:0] ring_phase;
    } lamp_beat_t;

    // Register copy
    logic [15:0] frame_gap;
    logic [31:0] hold_ms;
    logic [7:0]  fade_amt;
    logic [7:0]  full_lvl;
    logic [15:0] reveal_ms;
    logic [15:0] flash_ms;
    logic [4:0]  ring_total;
    logic        ring_en;

    // Lighting state
    logic        alarm_q;
    logic        flash_q;
    logic [31:0] flash_t;
    logic [31:0] frame_t;
    lamp_mode_t  hall_mode;
    logic [7:0]  hall_lvl;
    logic [31:0] hall_due;
    lamp_mode_t  ring_mode_q;
    logic [4:0]  ring_pos;
    logic [7:0]  ring_lvl;
    logic [31:0] ring_step_t;
    logic [31:0] ring_due;

    lamp_beat_t pending_lamp_beats[$];

    initial fail_count = 0;

    task automatic clear_lamp_state();
        frame_gap   = RST_FRAME_INTERVAL;
        hold_ms     = RST_HOLD_TIME;
        fade_amt    = RST_FADE_STEP;
        full_lvl    = RST_FULL_BRIGHTNESS;
        reveal_ms   = RST_REVEAL_STEP_TIME;
        flash_ms    = RST_FLASH_PERIOD;
        ring_total  = RST_RING_COUNT;
        ring_en     = RST_RINGS_ENABLED;
        alarm_q     = 1'b0;
        flash_q     = 1'b0;
        flash_t     = '0;
        frame_t     = '0;
        hall_mode   = LAMP_OFF;
        hall_lvl    = '0;
        hall_due    = '0;
        ring_mode_q = LAMP_OFF;
        ring_pos    = '0;
        ring_lvl    = '0;
        ring_step_t = '0;
        ring_due    = '0;
    endtask

    task automatic write_lamp_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            CFG_FRAME_INTERVAL:   frame_gap  = val[15:0];
            CFG_HOLD_TIME:        hold_ms    = val;
            CFG_FADE_STEP:        fade_amt   = val[7:0];
            CFG_FULL_BRIGHTNESS:  full_lvl   = val[7:0];
            CFG_REVEAL_STEP_TIME: reveal_ms  = val[15:0];
            CFG_FLASH_PERIOD:     flash_ms   = val[15:0];
            CFG_RING_COUNT:       ring_total = val[4:0];
            CFG_RINGS_ENABLED:    ring_en    = val[0];
            default: ;
        endcase
    endtask

    // Ring count clamped to 1..MAX_RINGS
    function automatic logic [4:0] rings_in_use();
        if (ring_total == 5'd0)
            return 5'd1;
        if (ring_total > MAX_RINGS)
            return 5'(MAX_RINGS);
        return ring_total;
    endfunction

    // Wrapping compare: deadline counts as reached once now - due is not negative
    function automatic logic deadline_passed(logic [31:0] now, logic [31:0] due);
        logic [31:0] diff;
        diff = now - due;
        return !diff[31];
    endfunction

    function automatic void rings_dark();
        ring_mode_q = LAMP_OFF;
        ring_pos    = '0;
        ring_lvl    = '0;
    endfunction

    function automatic void dim_lamp(inout logic [7:0] lvl, inout lamp_mode_t mode);
        if (lvl <= fade_amt) begin
            lvl  = '0;
            mode = LAMP_OFF;
        end else begin
            lvl = lvl - fade_amt;
        end
    endfunction

    function automatic void step_rings(logic [31:0] now);
        logic [31:0] span;
        span = now - ring_step_t;
        case (ring_mode_q)
            LAMP_RISE: begin
                if (span >= {16'd0, reveal_ms}) begin
                    ring_step_t = now;
                    ring_pos    = ring_pos + 5'd1;
                    if (ring_pos >= rings_in_use()) begin
                        ring_mode_q = LAMP_HOLD;
                        ring_due    = now + hold_ms;
                    end
                end
            end
            LAMP_HOLD: begin
                if (deadline_passed(now, ring_due))
                    ring_mode_q = LAMP_FALL;
            end
            LAMP_FALL: dim_lamp(ring_lvl, ring_mode_q);
            default: ;
        endcase
    endfunction

    function automatic void step_corridor(logic [31:0] now);
        logic [8:0] sum;
        sum = {1'b0, hall_lvl} + {1'b0, fade_amt};
        case (hall_mode)
            LAMP_RISE: begin
                // fade in lands on full brightness; deadline stays as motion set it
                if (sum >= {1'b0, full_lvl}) begin
                    hall_lvl  = full_lvl;
                    hall_mode = LAMP_HOLD;
                end else begin
                    hall_lvl = sum[7:0];
                end
            end
            LAMP_HOLD: begin
                if (deadline_passed(now, hall_due))
                    hall_mode = LAMP_FALL;
            end
            LAMP_FALL: dim_lamp(hall_lvl, hall_mode);
            default: ;
        endcase
    endfunction

    // Apply one event to the lighting state and report the result beat
    function automatic lamp_beat_t next_lamp_state(logic [2:0] kind, logic [31:0] now);
        lamp_beat_t r;
        logic       taken;
        taken = 1'b0;
        if (!ring_en)
            rings_dark();

        case (kind)
            EV_TICK: begin
                if (now - frame_t >= {16'd0, frame_gap}) begin
                    taken   = 1'b1;
                    frame_t = now;
                    if (alarm_q) begin
                        // alarm mode only toggles the flash
                        if (now - flash_t >= {16'd0, flash_ms}) begin
                            flash_t = now;
                            flash_q = !flash_q;
                        end
                    end else begin
                        if (ring_en)
                            step_rings(now);
                        step_corridor(now);
                    end
                end
            end
            EV_CORRIDOR: begin
                if (!alarm_q) begin
                    hall_due = now + hold_ms;
                    if (hall_mode == LAMP_OFF || hall_mode == LAMP_FALL)
                        hall_mode = LAMP_RISE;
                end
            end
            EV_RING: begin
                if (!alarm_q && ring_en) begin
                    ring_due = now + hold_ms;
                    if (ring_mode_q == LAMP_OFF) begin
                        ring_mode_q = LAMP_RISE;
                        ring_pos    = '0;
                        ring_lvl    = full_lvl;
                        ring_step_t = now;
                    end else if (ring_mode_q == LAMP_FALL) begin
                        ring_mode_q = LAMP_HOLD;
                        ring_lvl    = full_lvl;
                    end
                end
            end
            EV_ALARM_SET: begin
                alarm_q = 1'b1;
                flash_q = 1'b1;
                flash_t = '0;
            end
            EV_ALARM_CLR: begin
                alarm_q   = 1'b0;
                hall_mode = LAMP_OFF;
                hall_lvl  = '0;
                rings_dark();
            end
            default: ;  // unknown kinds leave the state alone
        endcase

        r.frame_taken    = taken;
        r.alarm_on       = alarm_q;
        r.flash_lit      = alarm_q & flash_q;
        r.corridor_level = (hall_mode != LAMP_OFF) ? hall_lvl : 8'd0;
        r.corridor_phase = hall_mode;
        if (ring_mode_q == LAMP_RISE)
            r.rings_shown = ring_pos;
        else if (ring_mode_q != LAMP_OFF)
            r.rings_shown = rings_in_use();
        else
            r.rings_shown = 5'd0;
        r.ring_level = (ring_mode_q != LAMP_OFF) ? ring_lvl : 8'd0;
        r.ring_phase = ring_mode_q;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Result side first, then the new event, then register writes
    always @(posedge aclk) begin : watch
        lamp_beat_t want;
        if (!aresetn) begin
            clear_lamp_state();
            pending_lamp_beats.delete();
            lamp_beats_due <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_lamp_beats.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    fail_count++;
                end else begin
                    want = pending_lamp_beats.pop_front();
                    check_field("frame_taken",    want.frame_taken,    m_frame_taken);
                    check_field("alarm_on",       want.alarm_on,       m_alarm_on);
                    check_field("flash_lit",      want.flash_lit,      m_flash_lit);
                    check_field("corridor_level", want.corridor_level, m_corridor_level);
                    check_field("corridor_phase", want.corridor_phase, m_corridor_phase);
                    check_field("rings_shown",    want.rings_shown,    m_rings_shown);
                    check_field("ring_level",     want.ring_level,     m_ring_level);
                    check_field("ring_phase",     want.ring_phase,     m_ring_phase);
                end
            end
            if (s_valid && s_ready)
                pending_lamp_beats.push_back(next_lamp_state(s_kind, s_now));
            if (cfg_we)
                write_lamp_reg(cfg_index, cfg_data);
            lamp_beats_due <= pending_lamp_beats.size();
        end
    end

endmodule

// ----- tb/tb_motion_light_fade_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motion_light_fade_controller
// Drives time-stamped lighting events into the controller under a series of
// register settings: a directed opening, then random event streams with
// varying backpressure. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_motion_light_fade_controller;
    import mlfc_pkg::*;

    localparam int QUIET_LIMIT   = 3000;
    localparam int RANDOM_EVENTS = 1500;
    localparam int PHASES        = 6;
    localparam int PARK_CYCLES   = 80;

    typedef struct {
        logic [15:0] frame_gap;
        logic [31:0] hold_ms;
        logic [7:0]  fade_amt;
        logic [7:0]  full_lvl;
        logic [15:0] reveal_ms;
        logic [15:0] flash_ms;
        logic [4:0]  rings;
        logic        ring_en;
    } lamp_cfg_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic [2:0]  s_kind    = EV_TICK;
    logic [31:0] s_now     = '0;
    logic        m_ready   = 1'b0;

    logic        s_ready;
    logic        m_valid;
    logic        m_frame_taken;
    logic        m_alarm_on;
    logic        m_flash_lit;
    logic [7:0]  m_corridor_level;
    logic [1:0]  m_corridor_phase;
    logic [4:0]  m_rings_shown;
    logic [7:0]  m_ring_level;
    logic [1:0]  m_ring_phase;

    int          lamp_beats_due;
    int          fail_count;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        park_token  = 1'b0;
    logic        park_seen   = 1'b0;
    int          park_left   = 0;
    int          quiet_cycles = 0;
    logic [31:0] clock_ms = '0;
    int          step_cap = 16;

    initial forever #6 aclk = ~aclk;

    motion_light_fade_controller u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_now            (s_now),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_taken    (m_frame_taken),
        .m_alarm_on       (m_alarm_on),
        .m_flash_lit      (m_flash_lit),
        .m_corridor_level (m_corridor_level),
        .m_corridor_phase (m_corridor_phase),
        .m_rings_shown    (m_rings_shown),
        .m_ring_level     (m_ring_level),
        .m_ring_phase     (m_ring_phase)
    );

    lamp_state_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_now            (s_now),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_taken    (m_frame_taken),
        .m_alarm_on       (m_alarm_on),
        .m_flash_lit      (m_flash_lit),
        .m_corridor_level (m_corridor_level),
        .m_corridor_phase (m_corridor_phase),
        .m_rings_shown    (m_rings_shown),
        .m_ring_level     (m_ring_level),
        .m_ring_phase     (m_ring_phase),
        .lamp_beats_due   (lamp_beats_due),
        .fail_count       (fail_count)
    );

    // Result side: random stalls, plus a long park whenever the token flips
    always @(posedge aclk) begin : result_sink
        if (park_token != park_seen) begin
            park_seen = park_token;
            park_left = PARK_CYCLES;
        end
        if (park_left > 0) begin
            park_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: ends the run after too many cycles without any beat moving
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic apply_settings(lamp_cfg_t c);
        write_reg(CFG_FRAME_INTERVAL,   {16'd0, c.frame_gap});
        write_reg(CFG_HOLD_TIME,        c.hold_ms);
        write_reg(CFG_FADE_STEP,        {24'd0, c.fade_amt});
        write_reg(CFG_FULL_BRIGHTNESS,  {24'd0, c.full_lvl});
        write_reg(CFG_REVEAL_STEP_TIME, {16'd0, c.reveal_ms});
        write_reg(CFG_FLASH_PERIOD,     {16'd0, c.flash_ms});
        write_reg(CFG_RING_COUNT,       {27'd0, c.rings});
        write_reg(CFG_RINGS_ENABLED,    {31'd0, c.ring_en});
        cfg_we   <= 1'b0;
        step_cap = int'(c.frame_gap) + int'(c.frame_gap) / 2 + 12;
    endtask

    // Stop offering and wait until every expected result beat is back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (lamp_beats_due != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // One event beat; valid stays up across back-to-back beats
    task automatic send_event(logic [2:0] kind, logic [31:0] now);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_now   <= now;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Mostly ticks with motion mixed in; alarms are short and unknown kinds rare
    task automatic random_event();
        int         roll;
        logic [2:0] kind;
        roll = $urandom_range(99);
        if (roll < 58)
            kind = EV_TICK;
        else if (roll < 73)
            kind = EV_CORRIDOR;
        else if (roll < 86)
            kind = EV_RING;
        else if (roll < 88)
            kind = EV_ALARM_SET;
        else if (roll < 96)
            kind = EV_ALARM_CLR;
        else
            kind = EV_ALARM_CLR + 3'($urandom_range(1, 3));
        if ($urandom_range(199) == 0)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + 32'($urandom_range(0, step_cap));
        send_event(kind, clock_ms);
    endtask

    function automatic lamp_cfg_t pick_settings(int phase);
        lamp_cfg_t c;
        c.frame_gap = 16'($urandom_range(0, 25));
        c.hold_ms   = 32'($urandom_range(0, 600));
        c.fade_amt  = 8'($urandom_range(1, 40));
        c.full_lvl  = 8'($urandom_range(0, 255));
        c.reveal_ms = 16'($urandom_range(0, 60));
        c.flash_ms  = 16'($urandom_range(0, 80));
        c.rings     = 5'($urandom_range(0, 20));
        c.ring_en   = 1'b1;
        case (phase)
            0: c = '{16'd0, 32'd0, 8'd255, 8'd255, 16'd0, 16'd0, 5'd16, 1'b1};
            1: c = '{16'hFFFF, 32'hFFFF_FFFF, 8'd1, 8'd0, 16'hFFFF, 16'hFFFF, 5'd31, 1'b1};
            2: c.ring_en = 1'b0;
            3: begin
                // stalled fades and the lowest ring count
                c.fade_amt = 8'd0;
                c.rings    = 5'd0;
            end
            default: ;
        endcase
        return c;
    endfunction

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening: rate limit, fades, reveal, alarm, wrap of time
        apply_settings('{16'd10, 32'd40, 8'd100, 8'd250, 16'd5, 16'd30, 5'd2, 1'b1});
        send_event(EV_TICK,      32'd0);
        send_event(EV_ALARM_CLR + 3'd3, 32'd1);
        send_event(EV_CORRIDOR,  32'd10);
        send_event(EV_RING,      32'd10);
        send_event(EV_TICK,      32'd10);
        send_event(EV_TICK,      32'd15);
        send_event(EV_TICK,      32'd20);
        send_event(EV_TICK,      32'd30);
        send_event(EV_TICK,      32'd60);
        send_event(EV_RING,      32'd62);
        send_event(EV_TICK,      32'd80);
        send_event(EV_CORRIDOR,  32'd85);
        send_event(EV_ALARM_SET, 32'd90);
        send_event(EV_TICK,      32'd100);
        send_event(EV_CORRIDOR,  32'd105);
        send_event(EV_TICK,      32'd112);
        send_event(EV_TICK,      32'd140);
        send_event(EV_ALARM_CLR, 32'd145);
        send_event(EV_RING,      32'hFFFF_FFF0);
        send_event(EV_CORRIDOR,  32'hFFFF_FFF0);
        send_event(EV_TICK,      32'hFFFF_FFFF);
        send_event(EV_TICK,      32'h0000_0010);
        send_event(EV_TICK,      32'h0000_0020);
        send_event(EV_TICK,      32'h0000_0030);
        send_event(EV_TICK,      32'h8000_0030);
        send_event(EV_ALARM_CLR + 3'd1, 32'h5555_5555);
        send_event(EV_ALARM_CLR + 3'd2, 32'hAAAA_AAAA);
        clock_ms = 32'h8000_0030;

        // Random phases, each under its own settings and stall pattern
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            apply_settings(pick_settings(phase));
            if (phase < 2) begin
                tx_idle_pct = 17;
                rx_idle_pct <= 45;
            end else if (phase < 4) begin
                tx_idle_pct = 45;
                rx_idle_pct <= 17;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            // park the result side while events keep coming
            if (phase == 4)
                park_token <= ~park_token;
            for (int n = 0; n < RANDOM_EVENTS / PHASES; n++)
                random_event();
        end

        settle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
